### rtl/vdet_pkg.sv
// shared constants and types of the windowed vibration detector
`default_nettype none

package vdet_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int JOINTS     = 8;
	localparam int THR_W      = 15;
	localparam int WINDOW_DEF = 16;
	localparam int OUT_DEPTH  = 8;

	localparam logic [THR_W-1:0] THR_RESET = 15'd1024;

	// per-stage control shared by all lanes
	typedef struct packed {
		logic acc;
		logic vld_s1;
		logic full_s1;
		logic vld_s3;
		logic chk_s5;
	} lane_ctl_t;

	typedef struct packed {
		logic [JOINTS-1:0] axis_flags;
		logic              any_vibration;
	} res_t;

endpackage

`default_nettype wire

### rtl/vdet_if.sv
// channel interfaces: sample vector in, flag result out
`default_nettype none

interface vdet_in_if;
	import vdet_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] velocity_0;
	logic signed [SAMPLE_W-1:0] velocity_1;
	logic signed [SAMPLE_W-1:0] velocity_2;
	logic signed [SAMPLE_W-1:0] velocity_3;
	logic signed [SAMPLE_W-1:0] velocity_4;
	logic signed [SAMPLE_W-1:0] velocity_5;
	logic signed [SAMPLE_W-1:0] velocity_6;
	logic signed [SAMPLE_W-1:0] velocity_7;

	modport source (
		output valid, velocity_0, velocity_1, velocity_2, velocity_3,
		output velocity_4, velocity_5, velocity_6, velocity_7,
		input  ready
	);
	modport sink (
		input  valid, velocity_0, velocity_1, velocity_2, velocity_3,
		input  velocity_4, velocity_5, velocity_6, velocity_7,
		output ready
	);
endinterface

interface vdet_out_if;
	import vdet_pkg::*;

	logic              valid;
	logic              ready;
	logic [JOINTS-1:0] axis_flags;
	logic              any_vibration;

	modport source (output valid, axis_flags, any_vibration, input ready);
	modport sink (input valid, axis_flags, any_vibration, output ready);
endinterface

`default_nettype wire

### rtl/vdet_lane.sv
// one joint: sample window, running sums and the deviation test
`default_nettype none

module vdet_lane #(
	parameter int WINDOW = vdet_pkg::WINDOW_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  vdet_pkg::lane_ctl_t                  ctl,
	input  logic [$clog2(WINDOW)-1:0]            slot,
	input  logic signed [vdet_pkg::SAMPLE_W-1:0] sample,
	input  logic [31+2*$clog2(WINDOW)-1:0]       lim,
	output logic                                 flag_s6
);
	import vdet_pkg::*;

	localparam int LOGW  = $clog2(WINDOW);
	localparam int SUM_W = SAMPLE_W + LOGW;
	localparam int SQ_W  = 31 + LOGW;
	localparam int ACC_W = SQ_W + 1;
	localparam int NSQ_W = 31 + 2 * LOGW;
	localparam int D_W   = SAMPLE_W + 1;

	logic signed [SAMPLE_W-1:0] mem [WINDOW];
	logic signed [SAMPLE_W-1:0] old_s1;
	logic signed [SAMPLE_W-1:0] new_s1;
	logic signed [SAMPLE_W-1:0] old_eff;
	logic signed [D_W-1:0]      diff_c;
	logic signed [D_W-1:0]      pair_c;
	logic signed [D_W-1:0]      diff_s2;
	logic signed [D_W-1:0]      pair_s2;
	logic signed [2*D_W-1:0]    prod_c;
	logic signed [31:0]         prod_s3;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SUM_W-1:0]    sum_s3;
	logic signed [SUM_W-1:0]    sum_s4;
	logic signed [ACC_W-1:0]    sq_q;
	logic signed [2*SUM_W-1:0]  ssq_c;
	logic [NSQ_W-1:0]           nsq_s5;
	logic [NSQ_W-1:0]           ssq_s5;
	logic [NSQ_W:0]             bound_c;

	// before the window is full the oldest slot holds nothing yet
	assign old_eff = ctl.full_s1 ? old_s1 : '0;
	assign diff_c  = {new_s1[SAMPLE_W-1], new_s1} - {old_eff[SAMPLE_W-1], old_eff};
	assign pair_c  = {new_s1[SAMPLE_W-1], new_s1} + {old_eff[SAMPLE_W-1], old_eff};
	// new^2 - old^2 as a single product
	assign prod_c  = diff_s2 * pair_s2;
	assign ssq_c   = sum_s4 * sum_s4;
	assign bound_c = {1'b0, ssq_s5} + {1'b0, lim};

	// read of the oldest sample happens before it is overwritten
	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			old_s1    <= mem[slot];
			mem[slot] <= sample;
			new_s1    <= sample;
		end
		diff_s2 <= diff_c;
		pair_s2 <= pair_c;
		prod_s3 <= prod_c[31:0];
		sum_s3  <= sum_q;
		sum_s4  <= sum_s3;
		nsq_s5  <= NSQ_W'(sq_q[SQ_W-1:0]) * NSQ_W'(WINDOW);
		ssq_s5  <= ssq_c[NSQ_W-1:0];
		flag_s6 <= ctl.chk_s5 && ({1'b0, nsq_s5} > bound_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sq_q  <= '0;
		end else begin
			if (ctl.vld_s1) begin
				sum_q <= sum_q + SUM_W'(diff_c);
			end
			if (ctl.vld_s3) begin
				sq_q <= sq_q + ACC_W'(prod_s3);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/vdet_merge.sv
// merging stage: combines lane flags and queues results for the receiver
`default_nettype none

module vdet_merge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [vdet_pkg::JOINTS-1:0] flags,
	vdet_out_if.source                  out_ch
);
	import vdet_pkg::*;

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	res_t             fifo [OUT_DEPTH];
	res_t             head;
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign head                 = fifo[rd_q];
	assign out_ch.valid         = (cnt_q != '0);
	assign out_ch.axis_flags    = head.axis_flags;
	assign out_ch.any_vibration = head.any_vibration;
	assign pop                  = out_ch.valid & out_ch.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo[wr_q] <= '{axis_flags: flags, any_vibration: |flags};
		end
	end

	// room is guaranteed by the credit count at the input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/windowed_vibration_detector.sv
// top level of the windowed vibration detector
// in_ch carries one signed Q5.10 velocity sample per joint; each transfer
// yields exactly one transfer on out_ch with the per-joint flags and an
// any-joint flag. A joint is flagged when the population deviation of its
// last WINDOW samples is above the threshold register (cfg_we / cfg_wdata,
// unsigned Q5.10, reset 1.0); no joint is flagged before the window is full.
// Throughput: one item per cycle while in_ch.ready is high; each joint
// lane updates its running sums once per item. Pipeline: a result is
// offered on out_ch after the registered steps window read, sum update,
// square delta, sum-of-squares update, products, compare and an output queue.
// in_ch.ready stays high while fewer than eight items are in flight or
// queued; when the receiver stalls, results collect in the eight-entry
// queue and in_ch.ready falls once it would overflow. Reset empties the
// window, the sums and the queue and restores the threshold.
`default_nettype none

module windowed_vibration_detector #(
	parameter int WINDOW = vdet_pkg::WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	vdet_in_if.sink                    in_ch,
	vdet_out_if.source                 out_ch,
	input  logic                       cfg_we,
	input  logic [vdet_pkg::THR_W-1:0] cfg_wdata
);
	import vdet_pkg::*;

	localparam int LOGW   = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int NSQ_W  = 31 + 2 * LOGW;
	localparam int OCC_W  = $clog2(OUT_DEPTH + 1);

	logic signed [SAMPLE_W-1:0] vel [JOINTS];
	logic [JOINTS-1:0]          flags_s6;
	logic [THR_W-1:0]           thr_q;
	logic [2*THR_W-1:0]         tsq_q;
	logic [NSQ_W-1:0]           lim_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [LOGW-1:0]            ptr_q;
	logic [OCC_W-1:0]           occ_q;
	logic                       acc;
	logic                       pop;
	logic                       was_full;
	logic                       now_full;
	logic                       full_s1;
	logic [5:0]                 vld_q;
	logic [4:0]                 chk_q;
	lane_ctl_t                  ctl;

	assign vel[0] = in_ch.velocity_0;
	assign vel[1] = in_ch.velocity_1;
	assign vel[2] = in_ch.velocity_2;
	assign vel[3] = in_ch.velocity_3;
	assign vel[4] = in_ch.velocity_4;
	assign vel[5] = in_ch.velocity_5;
	assign vel[6] = in_ch.velocity_6;
	assign vel[7] = in_ch.velocity_7;

	assign in_ch.ready = (occ_q < OCC_W'(OUT_DEPTH));
	assign acc         = in_ch.valid & in_ch.ready;
	assign pop         = out_ch.valid & out_ch.ready;
	assign was_full    = (cnt_q == CNT_W'(WINDOW));
	assign now_full    = was_full | (cnt_q == CNT_W'(WINDOW - 1));

	// vld_q[k] marks stage s(k+1), chk_q[k] likewise for the full-window check
	assign ctl = '{acc: acc, vld_s1: vld_q[0], full_s1: full_s1,
		vld_s3: vld_q[2], chk_s5: chk_q[4]};

	// squared limit scaled by window^2, registered from thr_q through tsq_q into lim_q
	always_ff @(posedge clk) begin
		tsq_q <= thr_q * thr_q;
		lim_q <= NSQ_W'(tsq_q) * NSQ_W'(WINDOW * WINDOW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_RESET;
			cnt_q   <= '0;
			ptr_q   <= '0;
			occ_q   <= '0;
			full_s1 <= 1'b0;
			vld_q   <= '0;
			chk_q   <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (acc) begin
				if (!was_full) begin
					cnt_q <= cnt_q + 1'b1;
				end
				ptr_q <= (ptr_q == LOGW'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
			end
			unique case ({acc, pop})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
			full_s1 <= acc & was_full;
			vld_q   <= {vld_q[4:0], acc};
			chk_q   <= {chk_q[3:0], acc & now_full};
		end
	end

	for (genvar j = 0; j < JOINTS; j++) begin : g_lane
		vdet_lane #(
			.WINDOW (WINDOW)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.slot    (ptr_q),
			.sample  (vel[j]),
			.lim     (lim_q),
			.flag_s6 (flags_s6[j])
		);
	end

	vdet_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (vld_q[5]),
		.flags  (flags_s6),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire
